// ----- src/tfrc_pkg.sv -----
// ----------------------------------------------------------------------------
// tfrc_pkg
// Shared types and codes of the four-register 8-bit core: byte and word
// types, opcodes, status word codes and item function codes.
// ----------------------------------------------------------------------------
package tfrc_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] word_t;
  typedef logic [1:0]  reg_idx_t;

  // number of general registers and memory bytes
  localparam int REG_COUNT = 4;
  localparam int MEM_DEPTH = 256;

  // highest pc at which a two-byte fetch is still allowed
  localparam byte_t PC_FETCH_MAX = 8'd254;

  // item function codes
  localparam logic FUNC_MEM_WRITE = 1'b0;
  localparam logic FUNC_STEP      = 1'b1;

  // opcodes in instruction bits 3:1
  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_SUB    = 3'd1,
    OP_LOAD   = 3'd2,
    OP_STORE  = 3'd3,
    OP_JUMP   = 3'd4,
    OP_JUMPZ  = 3'd5,
    OP_JUMPNZ = 3'd6,
    OP_JUMPN  = 3'd7
  } op_t;

  // status word codes
  typedef enum logic [1:0] {
    PSW_POS  = 2'd0,
    PSW_ZERO = 2'd1,
    PSW_NEG  = 2'd2
  } psw_t;

endpackage

// ----- src/tfrc_in_if.sv -----
// ----------------------------------------------------------------------------
// tfrc_in_if
// Input channel of the core: one memory write or one instruction step per
// transfer.
// ----------------------------------------------------------------------------
interface tfrc_in_if
  import tfrc_pkg::*;
;
  logic  valid;
  logic  ready;
  logic  func;
  byte_t mem_address;
  byte_t mem_data;

  modport source (output valid, output func, output mem_address, output mem_data,
                  input ready);
  modport sink   (input valid, input func, input mem_address, input mem_data,
                  output ready);
endinterface

// ----- src/tfrc_out_if.sv -----
// ----------------------------------------------------------------------------
// tfrc_out_if
// Result channel of the core: the architectural state after each item.
// ----------------------------------------------------------------------------
interface tfrc_out_if
  import tfrc_pkg::*;
;
  logic       valid;
  logic       ready;
  logic       halted_flag;
  byte_t      program_counter;
  logic [1:0] status_word;
  word_t      instruction_word;
  byte_t      reg_a_value;
  byte_t      reg_b_value;
  byte_t      reg_c_value;
  byte_t      reg_d_value;

  modport source (output valid, output halted_flag, output program_counter,
                  output status_word, output instruction_word,
                  output reg_a_value, output reg_b_value,
                  output reg_c_value, output reg_d_value,
                  input ready);
  modport sink   (input valid, input halted_flag, input program_counter,
                  input status_word, input instruction_word,
                  input reg_a_value, input reg_b_value,
                  input reg_c_value, input reg_d_value,
                  output ready);
endinterface

// ----- src/tiny_four_register_cpu_core.sv -----
// ----------------------------------------------------------------------------
// tiny_four_register_cpu_core
// 8-bit core with four registers, pc, status word, halt flag and a
// 256-byte memory, driven one item at a time.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries items: func 0 writes mem_data to mem_address, func 1
//   executes one instruction. out_if returns one result per item, the
//   state after that item (halt flag, pc, status word, last instruction,
//   registers A to D).
//   An item is captured in the input register, executed from there and its
//   result is registered in the output register. One item per cycle is
//   sustained while the receiver takes results; a memory-operand load holds
//   the execute stage, since its data comes from a second registered read
//   of the same memory port that fetches the instruction.
//   The instruction bytes at pc and pc+1 are prefetched into registers
//   after every state change, so the fetch needs no read of its own.
//   Reset clears registers, pc, status, halt flag and the memory valid
//   bits, so the whole memory reads as zero at once; no clearing pass.
//   When the receiver stalls, the result waits in the output register, one
//   more item waits in the input register, then in_if.ready drops.
// ----------------------------------------------------------------------------
module tiny_four_register_cpu_core
  import tfrc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  tfrc_in_if.sink   in_if,
  tfrc_out_if.source out_if
);

  // architectural state
  byte_t regs_r [REG_COUNT];
  byte_t pc_r;
  psw_t  flags_r;
  word_t ir_r;
  logic  halt_r;

  // input register
  logic  in_valid_r;
  logic  in_func_r;
  byte_t in_addr_r;
  byte_t in_data_r;

  // output register
  logic  out_valid_r;
  logic  out_halt_r;
  byte_t out_pc_r;
  psw_t  out_psw_r;
  word_t out_ir_r;
  byte_t out_regs_r [REG_COUNT];

  // memory and its read registers
  byte_t                mem_r [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] valid_r;
  byte_t hi_raw_r, lo_raw_r, ld_raw_r, wd_r;
  logic  hi_vld_r, lo_vld_r, ld_vld_r, hi_byp_r, lo_byp_r;
  logic  ld_phase_r;

  // control
  logic  in_ready, fire, out_space, need_ld, ld_first;
  logic  is_step, at_end, take;
  byte_t fetch_hi, fetch_lo, ld_data;
  word_t fetch_word;
  logic  mode;
  op_t   op;
  reg_idx_t s_idx, t_idx, d_idx;
  byte_t imm, pc_adv, ea_mode1, ld_addr, jmp_target;
  byte_t alu_x, alu_y, alu_res;
  psw_t  alu_psw;

  // next state
  byte_t regs_c [REG_COUNT];
  byte_t pc_c;
  psw_t  flags_c;
  word_t ir_c;
  logic  halt_c;
  logic  we_c;
  byte_t wa_c, wd_c;

  byte_t pc_nxt;
  logic  mem_we;
  byte_t mem_wa, mem_wd;
  byte_t addr_a, addr_b;

  // handshake
  assign out_space = !out_valid_r || out_if.ready;
  assign ld_first  = in_valid_r && need_ld && !ld_phase_r;
  assign fire      = in_valid_r && (!need_ld || ld_phase_r) && out_space;
  assign in_ready  = !in_valid_r || fire;
  assign in_if.ready = in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_ready) begin
      in_func_r <= in_if.func;
      in_addr_r <= in_if.mem_address;
      in_data_r <= in_if.mem_data;
    end
  end

  // prefetched bytes with write bypass; unwritten bytes read as zero
  assign fetch_hi   = hi_byp_r ? wd_r : (hi_vld_r ? hi_raw_r : '0);
  assign fetch_lo   = lo_byp_r ? wd_r : (lo_vld_r ? lo_raw_r : '0);
  assign ld_data    = ld_vld_r ? ld_raw_r : '0;
  assign fetch_word = {fetch_hi, fetch_lo};

  // decode
  assign mode   = fetch_word[0];
  assign op     = op_t'(fetch_word[3:1]);
  assign s_idx  = fetch_word[5:4];
  assign t_idx  = fetch_word[7:6];
  assign d_idx  = fetch_word[9:8];
  assign imm    = fetch_word[15:8];
  assign pc_adv = pc_r + 8'd2;

  assign is_step = (in_func_r == FUNC_STEP);
  assign at_end  = (pc_r > PC_FETCH_MAX);

  // effective addresses
  assign ea_mode1   = (s_idx == 2'd0) ? imm : regs_r[s_idx] + imm;
  assign ld_addr    = mode ? ea_mode1 : regs_r[s_idx];
  assign jmp_target = mode ? ((s_idx == 2'd0) ? imm : pc_adv + fetch_word[14:7])
                           : regs_r[s_idx];

  // memory-operand load needs a second registered read of the memory
  assign need_ld = in_valid_r && is_step && !halt_r && !at_end && (op == OP_LOAD)
                   && (mode || (t_idx == 2'd0));

  // alu
  assign alu_x   = regs_r[s_idx];
  assign alu_y   = mode ? imm : regs_r[t_idx];
  assign alu_res = (op == OP_SUB) ? alu_x - alu_y : alu_x + alu_y;

  always_comb begin
    if (alu_res == 8'd0) begin
      alu_psw = PSW_ZERO;
    end else if (alu_res[7]) begin
      alu_psw = PSW_NEG;
    end else begin
      alu_psw = PSW_POS;
    end
  end

  // branch condition
  always_comb begin
    case (op)
      OP_JUMP:   take = 1'b1;
      OP_JUMPZ:  take = (flags_r == PSW_ZERO);
      OP_JUMPNZ: take = (flags_r == PSW_POS);
      OP_JUMPN:  take = (flags_r == PSW_NEG);
      default:   take = 1'b0;
    endcase
  end

  // execute
  always_comb begin
    regs_c  = regs_r;
    pc_c    = pc_r;
    flags_c = flags_r;
    ir_c    = ir_r;
    halt_c  = halt_r;
    we_c    = 1'b0;
    wa_c    = in_addr_r;
    wd_c    = in_data_r;
    if (!is_step) begin
      we_c = 1'b1;
    end else if (!halt_r) begin
      if (at_end) begin
        halt_c = 1'b1;
      end else begin
        ir_c = fetch_word;
        pc_c = pc_adv;
        case (op)
          OP_ADD, OP_SUB: begin
            regs_c[mode ? t_idx : d_idx] = alu_res;
            flags_c = alu_psw;
          end
          OP_LOAD: begin
            if (mode) begin
              regs_c[t_idx] = ld_data;
            end else if (t_idx == 2'd0) begin
              regs_c[d_idx] = ld_data;
            end
          end
          OP_STORE: begin
            if (mode) begin
              we_c = 1'b1;
              wa_c = ea_mode1;
              wd_c = regs_r[t_idx];
            end else if (t_idx == 2'd0) begin
              we_c = 1'b1;
              wa_c = regs_r[d_idx];
              wd_c = regs_r[s_idx];
            end else begin
              regs_c[d_idx] = regs_r[s_idx];
            end
          end
          default: begin
            if (!mode && (fetch_word[15:6] != 10'd0)) begin
              halt_c = 1'b1;
            end else if (take) begin
              pc_c = jmp_target;
            end
          end
        endcase
      end
    end
  end

  assign pc_nxt = fire ? pc_c : pc_r;
  assign mem_we = fire && we_c;
  assign mem_wa = wa_c;
  assign mem_wd = wd_c;

  // read port a serves the load operand while a load waits, else pc
  assign addr_a = ld_first ? ld_addr : pc_nxt;
  assign addr_b = pc_nxt + 8'd1;

  // architectural state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        regs_r[i] <= '0;
      end
      pc_r       <= '0;
      flags_r    <= PSW_POS;
      ir_r       <= '0;
      halt_r     <= 1'b0;
      ld_phase_r <= 1'b0;
    end else begin
      if (fire) begin
        regs_r  <= regs_c;
        pc_r    <= pc_c;
        flags_r <= flags_c;
        ir_r    <= ir_c;
        halt_r  <= halt_c;
      end
      if (fire) begin
        ld_phase_r <= 1'b0;
      end else if (ld_first) begin
        ld_phase_r <= 1'b1;
      end
    end
  end

  // memory array and registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    if (ld_first) begin
      ld_raw_r <= mem_r[addr_a];
    end else begin
      hi_raw_r <= mem_r[addr_a];
      lo_raw_r <= mem_r[addr_b];
      wd_r     <= mem_wd;
    end
  end

  // written-byte flags and bypass flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      hi_vld_r <= 1'b0;
      lo_vld_r <= 1'b0;
      ld_vld_r <= 1'b0;
      hi_byp_r <= 1'b0;
      lo_byp_r <= 1'b0;
    end else begin
      if (mem_we) begin
        valid_r[mem_wa] <= 1'b1;
      end
      if (ld_first) begin
        ld_vld_r <= valid_r[addr_a];
      end else begin
        hi_vld_r <= valid_r[addr_a];
        lo_vld_r <= valid_r[addr_b];
        hi_byp_r <= mem_we && (mem_wa == addr_a);
        lo_byp_r <= mem_we && (mem_wa == addr_b);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_halt_r <= halt_c;
      out_pc_r   <= pc_c;
      out_psw_r  <= flags_c;
      out_ir_r   <= ir_c;
      out_regs_r <= regs_c;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.halted_flag      = out_halt_r;
  assign out_if.program_counter  = out_pc_r;
  assign out_if.status_word      = out_psw_r;
  assign out_if.instruction_word = out_ir_r;
  assign out_if.reg_a_value      = out_regs_r[0];
  assign out_if.reg_b_value      = out_regs_r[1];
  assign out_if.reg_c_value      = out_regs_r[2];
  assign out_if.reg_d_value      = out_regs_r[3];

`ifndef ASSERT_OFF
  // a halted core keeps its pc on every further transfer
  a_halt_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
    fire && halt_r |=> pc_r == $past(pc_r))
    else $error("pc changed while halted");

  // the instruction register takes the prefetched word on a real fetch
  a_fetch_word: assert property (@(posedge clk) disable iff (!rst_n)
    fire && is_step && !halt_r && !at_end |=> ir_r == $past(fetch_word))
    else $error("instruction register differs from fetched word");

  // the load phase only exists while an item with a pending load is held
  a_ld_phase_item: assert property (@(posedge clk) disable iff (!rst_n)
    ld_phase_r |-> in_valid_r && need_ld)
    else $error("load phase without a pending load");

  // only reset clears the halt flag
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(halt_r))
    else $error("halt flag cleared");

  // a new result appears only after an execute transfer
  a_out_from_fire: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(fire))
    else $error("result without execution");
`endif

endmodule

// ----- dv/tfrc_core_checker.sv -----
// ----------------------------------------------------------------------------
// tfrc_core_checker
// Watches both channels of the four-register core. It keeps its own copy of
// the architectural state, works out the state after every input transfer
// and compares each result transfer with the oldest state still waiting.
// ----------------------------------------------------------------------------
module tfrc_core_checker
  import tfrc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tfrc_in_if   in_ch,
  tfrc_out_if  out_ch,
  output int   fail_count,
  output int   outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // state reported after one item
  typedef struct packed {
    logic       halted;
    byte_t      pc;
    logic [1:0] psw;
    word_t      ir;
    byte_t      ra;
    byte_t      rb;
    byte_t      rc;
    byte_t      rd;
  } core_state_t;

  // architectural state of the core as the checker sees it
  byte_t gpr   [REG_COUNT];
  byte_t pc_q;
  psw_t  psw_q;
  word_t ir_q;
  logic  halt_q;
  byte_t mem_q [MEM_DEPTH];

  // states after accepted items, oldest first
  core_state_t arch_state_q [$];

  // fires once per rising edge, after the state above is up to date
  event sampled;

  function automatic psw_t status_of(byte_t r);
    if (r == 8'h00) return PSW_ZERO;
    if (r[7]) return PSW_NEG;
    return PSW_POS;
  endfunction

  // one memory write or one instruction step
  function automatic void apply_item(logic f, byte_t addr, byte_t data);
    word_t    w;
    op_t      op;
    logic     mode;
    reg_idx_t s;
    reg_idx_t t;
    reg_idx_t d;
    byte_t    imm;
    byte_t    lo_addr;
    byte_t    x;
    byte_t    y;
    byte_t    r;
    byte_t    ea;
    byte_t    target;
    logic     take;
    if (f == FUNC_MEM_WRITE) begin
      mem_q[addr] = data;
      return;
    end
    if (halt_q) return;
    // no room for a two-byte fetch
    if (pc_q > PC_FETCH_MAX) begin
      halt_q = 1'b1;
      return;
    end
    lo_addr = pc_q + 8'd1;
    w       = {mem_q[pc_q], mem_q[lo_addr]};
    ir_q    = w;
    pc_q    = pc_q + 8'd2;
    mode    = w[0];
    op      = op_t'(w[3:1]);
    s       = w[5:4];
    t       = w[7:6];
    d       = w[9:8];
    imm     = w[15:8];
    case (op)
      OP_ADD, OP_SUB: begin
        x = gpr[s];
        y = mode ? imm : gpr[t];
        r = (op == OP_ADD) ? x + y : x - y;
        if (mode) gpr[t] = r;
        else gpr[d] = r;
        psw_q = status_of(r);
      end
      OP_LOAD: begin
        if (mode) begin
          ea = (s == 2'd0) ? imm : gpr[s] + imm;
          gpr[t] = mem_q[ea];
        end else if (t == 2'd0) begin
          gpr[d] = mem_q[gpr[s]];
        end
        // other register form is a bank switch: single bank, nothing to do
      end
      OP_STORE: begin
        if (mode) begin
          ea = (s == 2'd0) ? imm : gpr[s] + imm;
          mem_q[ea] = gpr[t];
        end else if (t == 2'd0) begin
          mem_q[gpr[d]] = gpr[s];
        end else begin
          gpr[d] = gpr[s];
        end
      end
      default: begin
        // jumps: relative offset counts from the advanced pc
        if (mode) begin
          target = (s == 2'd0) ? imm : pc_q + w[14:7];
        end else if (w[15:6] == 10'd0) begin
          target = gpr[s];
        end else begin
          halt_q = 1'b1;
          return;
        end
        case (op)
          OP_JUMP:   take = 1'b1;
          OP_JUMPZ:  take = (psw_q == PSW_ZERO);
          OP_JUMPNZ: take = (psw_q == PSW_POS);
          default:   take = (psw_q == PSW_NEG);
        endcase
        if (take) pc_q = target;
      end
    endcase
  endfunction

  function automatic core_state_t state_now();
    core_state_t st;
    st.halted = halt_q;
    st.pc     = pc_q;
    st.psw    = psw_q;
    st.ir     = ir_q;
    st.ra     = gpr[0];
    st.rb     = gpr[1];
    st.rc     = gpr[2];
    st.rd     = gpr[3];
    return st;
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // compare result transfers, then fold in the input transfer of this edge
  always @(posedge clk) begin
    core_state_t want;
    if (!rst_n) begin
      for (int i = 0; i < REG_COUNT; i++) gpr[i] = 8'h00;
      for (int i = 0; i < MEM_DEPTH; i++) mem_q[i] = 8'h00;
      pc_q       = 8'h00;
      psw_q      = PSW_POS;
      ir_q       = 16'h0000;
      halt_q     = 1'b0;
      fail_count = 0;
      arch_state_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (arch_state_q.size() == 0) begin
          $display("%0t: result transfer expected none actual pc %h ir %h", $time,
                   out_ch.program_counter, out_ch.instruction_word);
          fail_count++;
        end else begin
          want = arch_state_q.pop_front();
          check_field("halted_flag", 16'(want.halted), 16'(out_ch.halted_flag));
          check_field("program_counter", 16'(want.pc), 16'(out_ch.program_counter));
          check_field("status_word", 16'(want.psw), 16'(out_ch.status_word));
          check_field("instruction_word", want.ir, out_ch.instruction_word);
          check_field("reg_a_value", 16'(want.ra), 16'(out_ch.reg_a_value));
          check_field("reg_b_value", 16'(want.rb), 16'(out_ch.reg_b_value));
          check_field("reg_c_value", 16'(want.rc), 16'(out_ch.reg_c_value));
          check_field("reg_d_value", 16'(want.rd), 16'(out_ch.reg_d_value));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_item(in_ch.func, in_ch.mem_address, in_ch.mem_data);
        arch_state_q.insert(arch_state_q.size(), state_now());
      end
    end
    outstanding = arch_state_q.size();
    -> sampled;
  end

endmodule

// ----- dv/tb_tiny_four_register_cpu_core.sv -----
// ----------------------------------------------------------------------------
// tb_tiny_four_register_cpu_core
// Stimulus for the four-register core: a short directed program, then
// random memory writes, program blocks and steps steered away from an early
// halt, and a halting sequence at the end. Checking is done by the checker.
// ----------------------------------------------------------------------------
module tb_tiny_four_register_cpu_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tfrc_pkg::*;

  // unconditional jump to address zero, always a safe step
  localparam word_t JUMP_HOME = {8'h00, 2'd0, 2'd0, OP_JUMP, 1'b1};

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   outstanding;
  int   sent_count = 0;
  logic quiet;
  bit   pressure_done = 1'b0;

  tfrc_in_if  in_if ();
  tfrc_out_if out_if ();

  tiny_four_register_cpu_core u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  tfrc_core_checker u_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  always #10 clk = ~clk;

  // stretch with no idling on either side
  assign quiet = (sent_count >= 200) && (sent_count < 320);

  // one input transfer, then a random gap
  task automatic send_item(logic f, byte_t addr, byte_t data);
    in_if.valid       <= 1'b1;
    in_if.func        <= f;
    in_if.mem_address <= addr;
    in_if.mem_data    <= data;
    do @(u_chk.sampled); while (in_if.ready !== 1'b1);
    sent_count++;
    while (!quiet && $urandom_range(0, 99) < 28) begin
      in_if.valid <= 1'b0;
      @(u_chk.sampled);
    end
  endtask

  task automatic step_item();
    send_item(FUNC_STEP, byte_t'($urandom), byte_t'($urandom));
  endtask

  // instruction words are big-endian in memory
  task automatic put_word(byte_t at, word_t w);
    send_item(FUNC_MEM_WRITE, at, w[15:8]);
    send_item(FUNC_MEM_WRITE, at + 8'd1, w[7:0]);
  endtask

  task automatic run_word(word_t w);
    put_word(u_chk.pc_q, w);
    step_item();
  endtask

  // true if stepping w at the current pc cannot halt the core
  function automatic bit step_is_safe(word_t w);
    byte_t nxt;
    byte_t target;
    nxt = u_chk.pc_q + 8'd2;
    if (!w[3]) return nxt != 8'hFF;
    if (!w[0]) begin
      if (w[15:6] != 10'd0) return 1'b0;
      target = u_chk.gpr[w[5:4]];
    end else if (w[5:4] == 2'd0) begin
      target = w[15:8];
    end else begin
      target = nxt + w[14:7];
    end
    if (target == 8'hFF) return 1'b0;
    if (op_t'(w[3:1]) == OP_JUMP) return 1'b1;
    return nxt != 8'hFF;
  endfunction

  // random instruction, biased toward register jumps and zero results
  function automatic word_t random_word();
    word_t w;
    w = word_t'($urandom);
    if (w[3] && !w[0] && $urandom_range(0, 2) != 0) w[15:6] = 10'd0;
    if (w[3:2] == 2'b00 && w[0] && $urandom_range(0, 5) == 0)
      w[15:8] = w[1] ? u_chk.gpr[w[5:4]] : 8'h00 - u_chk.gpr[w[5:4]];
    return w;
  endfunction

  function automatic word_t safe_word();
    word_t w;
    for (int i = 0; i < 64; i++) begin
      w = random_word();
      if (step_is_safe(w)) return w;
    end
    return JUMP_HOME;
  endfunction

  // result side: random stalls, one long hold-off
  initial begin
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (!pressure_done && sent_count >= 450) begin
        pressure_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (40) @(posedge clk);
      end
      out_if.ready <= quiet || ($urandom_range(0, 99) >= 28);
    end
  end

  // reset, stimulus and verdict
  initial begin
    int    k;
    byte_t p;
    word_t cur;
    in_if.valid       = 1'b0;
    in_if.func        = FUNC_MEM_WRITE;
    in_if.mem_address = 8'h00;
    in_if.mem_data    = 8'h00;
    rst_n             = 1'b0;
    repeat (12) @(u_chk.sampled);
    rst_n <= 1'b0 | 1'b1;

    // directed program: negative, zero, jump to the top word, move,
    // bank switch, backward relative jump, register jump, register add
    run_word({8'hFF, 2'd0, 2'd0, OP_ADD, 1'b1});
    run_word({8'hFF, 2'd1, 2'd0, OP_SUB, 1'b1});
    run_word({8'hFE, 2'd0, 2'd0, OP_JUMPZ, 1'b1});
    run_word({6'd0, 2'd2, 2'd1, 2'd0, OP_STORE, 1'b0});
    run_word({6'd0, 2'd3, 2'd2, 2'd1, OP_LOAD, 1'b0});
    run_word({8'h7E, 2'd0, 2'd1, OP_JUMP, 1'b1});
    run_word({6'd0, 2'd0, 2'd0, 2'd1, OP_JUMP, 1'b0});
    run_word({6'd0, 2'd3, 2'd2, 2'd0, OP_ADD, 1'b0});

    // random mix of noise writes, program blocks and steps
    while (sent_count < 700) begin
      p = u_chk.pc_q;
      k = $urandom_range(0, 99);
      if (k < 12) begin
        send_item(FUNC_MEM_WRITE, byte_t'($urandom), byte_t'($urandom));
      end else if (k < 20) begin
        repeat ($urandom_range(2, 6)) begin
          put_word(p, random_word());
          p = p + 8'd2;
        end
      end else begin
        cur = {u_chk.mem_q[p], u_chk.mem_q[p + 8'd1]};
        if (!step_is_safe(cur) || $urandom_range(0, 3) == 0) put_word(p, safe_word());
        step_item();
      end
    end

    // halt at the end: fetch above the last word pair, or the halt form
    if ($urandom_range(0, 1) != 0) begin
      run_word({8'hFF, 2'd0, 2'd0, OP_JUMP, 1'b1});
      step_item();
    end else begin
      run_word({8'hFF, 2'd3, 2'd1, OP_JUMPN, 1'b0});
    end
    // step while halted, memory write while halted
    step_item();
    send_item(FUNC_MEM_WRITE, byte_t'($urandom), byte_t'($urandom));
    step_item();
    in_if.valid <= 1'b0;

    wait (outstanding == 0);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_tiny_four_register_cpu_core OK");
    end else begin
      $display("tb_tiny_four_register_cpu_core NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("tb_tiny_four_register_cpu_core NOT OK");
    $finish;
  end

endmodule
